[design/block_tape_controller_registers_macros.svh]
// ----------------------------------------------------------------------------
// Tape controller register file assertion macros
// Clocked property checks, switched off together by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TAPE_CONTROLLER_REGISTERS_MACROS_SVH
`define BLOCK_TAPE_CONTROLLER_REGISTERS_MACROS_SVH

`ifndef ASSERT_OFF
// check while out of reset
`define BTC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btc assertion failed");
// check at every edge, reset included
`define BTC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("btc assertion failed");
`else
`define BTC_ASSERT(label, prop)
`define BTC_ASSERT_ALWAYS(label, prop)
`endif

`endif

[design/btc_pkg.sv]
// ----------------------------------------------------------------------------
// Tape controller register file package
// Register bit masks, codes and the state and result types.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int BLOCK_WORDS = 256;
    localparam int BLOCK_BYTES = 2 * BLOCK_WORDS;
    localparam int ROOM_W      = 16 + $clog2(BLOCK_BYTES);

    localparam logic [15:0] NUM_BLOCKS_RESET = 16'd578;

    localparam logic [15:0] CM_GO   = 16'h0001;
    localparam logic [15:0] CM_IE   = 16'h0040;
    localparam logic [15:0] CM_DONE = 16'h0080;
    localparam logic [15:0] CM_DIR  = 16'h0800;
    localparam logic [15:0] CM_ERR  = 16'h8000;

    localparam logic [15:0] ST_END  = 16'h8000;
    localparam logic [15:0] ST_ILO  = 16'h1000;
    localparam logic [15:0] ST_UPS  = 16'h0080;
    localparam logic [15:0] ST_ERRS = ST_END | ST_ILO;

    typedef enum logic
    {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        REG_STATUS  = 3'd0,
        REG_COMMAND = 3'd1,
        REG_COUNT   = 3'd2,
        REG_ADDRESS = 3'd3,
        REG_DATA    = 3'd4
    } reg_index_t;

    typedef enum logic [2:0]
    {
        FN_STOP         = 3'd0,
        FN_SEARCH       = 3'd1,
        FN_READ         = 3'd2,
        FN_READ_ALL     = 3'd3,
        FN_SSEL         = 3'd4,
        FN_WRITE_ALL    = 3'd5,
        FN_WRITE        = 3'd6,
        FN_WRITE_TIMING = 3'd7
    } func_t;

    typedef struct packed
    {
        logic [15:0] status;
        logic [15:0] command;
        logic [15:0] word_count;
        logic [15:0] bus_address;
        logic [15:0] data;
        logic [15:0] head_block;
        logic        irq;
    } ctl_state_t;

    typedef struct packed
    {
        logic [15:0] read_data;
        logic        irq;
        logic        dma_request;
        logic        dma_to_memory;
        logic [15:0] dma_block;
        logic [15:0] dma_bus_address;
        logic [16:0] dma_bytes;
    } result_t;

endpackage

[design/btc_if.sv]
// ----------------------------------------------------------------------------
// Tape controller register file channels
// Valid/ready channels for bus access beats and result beats.
// ----------------------------------------------------------------------------
interface btc_access_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  reg_index;
    logic [15:0] write_data;
    logic        dma_error;

    modport source (output valid, output op, output reg_index, output write_data,
                    output dma_error, input ready);
    modport sink (input valid, input op, input reg_index, input write_data,
                  input dma_error, output ready);
endinterface

interface btc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        irq;
    logic        dma_request;
    logic        dma_to_memory;
    logic [15:0] dma_block;
    logic [15:0] dma_bus_address;
    logic [16:0] dma_bytes;

    modport source (output valid, output read_data, output irq, output dma_request,
                    output dma_to_memory, output dma_block, output dma_bus_address,
                    output dma_bytes, input ready);
    modport sink (input valid, input read_data, input irq, input dma_request,
                  input dma_to_memory, input dma_block, input dma_bus_address,
                  input dma_bytes, output ready);
endinterface

[design/block_tape_controller_registers.sv]
// A result beat appears in the cycle after its access beat is taken.
// Throughput: one access beat per cycle while the result register drains, set by that single register.
// Reset (rst_n low, asynchronous): registers take their power-on values,
// the tape size returns to 578 blocks and the result register empties.
// ----------------------------------------------------------------------------
// Tape controller register file
// Bus register file of a block-addressed tape controller with DMA requests.
// ----------------------------------------------------------------------------
`include "block_tape_controller_registers_macros.svh"

module block_tape_controller_registers
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic [15:0]  cfg_write_data,
    btc_access_if.sink   access,
    btc_result_if.source result
);
    import btc_pkg::*;

    ctl_state_t  state_reg;
    ctl_state_t  state_next;
    result_t     result_reg;
    result_t     result_next;
    logic        result_valid_reg;
    logic [15:0] num_blocks_reg;
    logic        accept;

    assign access.ready = !result_valid_reg || result.ready;
    assign accept       = access.valid && access.ready;

    btc_core u_core
    (
        .cur        (state_reg),
        .num_blocks (num_blocks_reg),
        .op         (access.op),
        .reg_index  (access.reg_index),
        .write_data (access.write_data),
        .dma_error  (access.dma_error),
        .nxt        (state_next),
        .res        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.status      <= ST_UPS;
            state_reg.command     <= CM_DONE;
            state_reg.word_count  <= 16'd0;
            state_reg.bus_address <= 16'd0;
            state_reg.data        <= 16'd0;
            state_reg.head_block  <= 16'd0;
            state_reg.irq         <= 1'b0;
            num_blocks_reg        <= NUM_BLOCKS_RESET;
            result_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                num_blocks_reg <= cfg_write_data;
            end
            if (accept)
            begin
                state_reg        <= state_next;
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // hold the payload until the next beat is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid           = result_valid_reg;
    assign result.read_data       = result_reg.read_data;
    assign result.irq             = result_reg.irq;
    assign result.dma_request     = result_reg.dma_request;
    assign result.dma_to_memory   = result_reg.dma_to_memory;
    assign result.dma_block       = result_reg.dma_block;
    assign result.dma_bus_address = result_reg.dma_bus_address;
    assign result.dma_bytes       = result_reg.dma_bytes;

    `BTC_ASSERT_ALWAYS(a_cmd_go_clear, !state_reg.command[0])
    `BTC_ASSERT(a_accept_fills, accept |=> result_valid_reg)
    `BTC_ASSERT(a_dma_no_read_data, (result.valid && result.dma_request) |-> (result.read_data == 16'd0))
    `BTC_ASSERT(a_dma_clears_count, (result.valid && result.dma_request) |-> (state_reg.word_count == 16'd0))

endmodule

[design/btc_core.sv]
// ----------------------------------------------------------------------------
// Tape controller access decode
// Next register state and result of one bus access, including command execution.
// ----------------------------------------------------------------------------
module btc_core
(
    input  btc_pkg::ctl_state_t cur,
    input  logic [15:0]         num_blocks,
    input  logic                op,
    input  logic [2:0]          reg_index,
    input  logic [15:0]         write_data,
    input  logic                dma_error,
    output btc_pkg::ctl_state_t nxt,
    output btc_pkg::result_t    res
);
    import btc_pkg::*;

    func_t                 fn;
    logic [15:0]           cm;
    logic [15:0]           st;
    logic [15:0]           words;
    logic [16:0]           bytes;
    logic [15:0]           room;
    logic [ROOM_W-1:0]     room_bytes;
    logic                  head_below;
    logic                  in_bounds;
    logic                  fwd_ok;
    logic [15:0]           head_new;
    logic [15:0]           cm_done;

    function automatic logic cm_dir_set(input logic [15:0] v);
        return (v & CM_DIR) != 16'd0;
    endfunction

    always_comb
    begin
        fn         = func_t'(write_data[3:1]);
        words      = 16'(16'd0 - cur.word_count);
        bytes      = {words, 1'b0};
        head_below = cur.head_block < num_blocks;
        room       = 16'(num_blocks - cur.head_block);
        room_bytes = ROOM_W'(room) * ROOM_W'(BLOCK_BYTES);
        in_bounds  = head_below && (ROOM_W'(bytes) <= room_bytes);
        fwd_ok     = (17'(cur.head_block) + 17'd1) < {1'b0, num_blocks};
        if ((cm_dir_set(write_data)))
        begin
            head_new = (cur.head_block != 16'd0) ? 16'(cur.head_block - 16'd1)
                                                 : cur.head_block;
        end
        else
        begin
            head_new = fwd_ok ? 16'(cur.head_block + 16'd1) : cur.head_block;
        end
    end

    always_comb
    begin
        nxt     = cur;
        res     = '0;
        cm      = write_data & ~(CM_DONE | CM_ERR);
        st      = cur.status & ~ST_ERRS;
        cm_done = (cm & ~CM_GO) | CM_DONE;
        if (op_t'(op) == OP_WRITE)
        begin
            case (reg_index_t'(reg_index))
                REG_COMMAND:
                begin
                    if ((write_data & CM_GO) != 16'd0)
                    begin
                        case (fn)
                            FN_SEARCH:
                            begin
                                nxt.head_block = head_new;
                                nxt.data       = head_new;
                            end
                            FN_READ, FN_WRITE:
                            begin
                                st = st | ST_UPS;
                                if (in_bounds)
                                begin
                                    res.dma_request     = 1'b1;
                                    res.dma_to_memory   = (fn == FN_READ);
                                    res.dma_block       = cur.head_block;
                                    res.dma_bus_address = cur.bus_address;
                                    res.dma_bytes       = bytes;
                                end
                                nxt.bus_address = 16'(cur.bus_address + bytes[15:0]);
                                nxt.word_count  = 16'd0;
                                if (!in_bounds || dma_error)
                                begin
                                    st = st | ST_END;
                                end
                            end
                            FN_STOP, FN_SSEL:
                            begin
                                st = st;
                            end
                            default:
                            begin
                                st = st | ST_ILO;
                            end
                        endcase
                        nxt.status  = st;
                        nxt.command = ((st & ST_ERRS) != 16'd0) ? (cm_done | CM_ERR)
                                                                : (cm_done & ~CM_ERR);
                        nxt.irq     = (cm & CM_IE) != 16'd0;
                    end
                    else
                    begin
                        nxt.command = write_data & ~CM_DONE;
                        nxt.irq     = 1'b0;
                    end
                end
                REG_COUNT:   nxt.word_count  = write_data;
                REG_ADDRESS: nxt.bus_address = write_data;
                REG_DATA:    nxt.data        = write_data;
                default:     nxt = cur;
            endcase
        end
        else
        begin
            case (reg_index_t'(reg_index))
                REG_STATUS:  res.read_data = cur.status;
                REG_COMMAND:
                begin
                    nxt.command   = {(cur.status & ST_ERRS) != 16'd0, cur.command[14:0]};
                    res.read_data = nxt.command;
                end
                REG_COUNT:   res.read_data = cur.word_count;
                REG_ADDRESS: res.read_data = cur.bus_address;
                REG_DATA:    res.read_data = cur.data;
                default:     res.read_data = 16'd0;
            endcase
        end
        res.irq = nxt.irq;
    end

endmodule

[dv/block_tape_controller_registers_tb.sv]
// ----------------------------------------------------------------------------
// Tape controller register file testbench
// Sends bus accesses under random flow control and tracks the controller's
// registers alongside. Each result beat is checked field by field against
// the tracked value. Directed cases cover the register map, every function
// and the tape ends. Random traffic then runs over several tape sizes.
// ----------------------------------------------------------------------------
module block_tape_controller_registers_tb;

    import btc_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [2:0]  LAST_UNMAPPED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;

    btc_access_if access_bus();
    btc_result_if result_bus();

    ctl_state_t  regs;
    logic [15:0] tape_blocks;
    result_t     due_responses[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatches;
    int cycle_count;

    block_tape_controller_registers uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .access         (access_bus),
        .result         (result_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] command_word(input func_t fn, input logic [15:0] flags);
        return flags | {12'd0, fn, 1'b0};
    endfunction

    function automatic result_t tape_ctl_response(input op_t op, input logic [2:0] idx,
                                                  input logic [15:0] wdata,
                                                  input logic refused);
        result_t     res;
        logic [15:0] cm;
        logic [2:0]  fn;
        logic [15:0] words;
        logic [16:0] bytes;
        int unsigned tape_bytes;
        int unsigned offset;
        logic        fits;
        res = '0;
        if (op == OP_WRITE)
        begin
            case (idx)
                REG_COMMAND:
                begin
                    regs.command = wdata & ~CM_DONE;
                    if ((wdata & CM_GO) != 16'd0)
                    begin
                        cm = wdata & ~(CM_DONE | CM_ERR);
                        fn = wdata[3:1];
                        regs.status = regs.status & ~ST_ERRS;
                        regs.command = cm;
                        case (func_t'(fn))
                            FN_SEARCH:
                            begin
                                if ((cm & CM_DIR) != 16'd0)
                                begin
                                    if (regs.head_block != 16'd0)
                                        regs.head_block = regs.head_block - 16'd1;
                                end
                                else if ({1'b0, regs.head_block} + 17'd1 < {1'b0, tape_blocks})
                                    regs.head_block = regs.head_block + 16'd1;
                                regs.data = regs.head_block;
                            end
                            FN_READ, FN_WRITE:
                            begin
                                words = 16'd0 - regs.word_count;
                                bytes = {words, 1'b0};
                                tape_bytes = tape_blocks * BLOCK_BYTES;
                                offset = regs.head_block * BLOCK_BYTES;
                                fits = (regs.head_block < tape_blocks) &&
                                       (offset + bytes <= tape_bytes);
                                regs.status = regs.status | ST_UPS;
                                if (fits)
                                begin
                                    res.dma_request = 1'b1;
                                    res.dma_to_memory = (func_t'(fn) == FN_READ);
                                    res.dma_block = regs.head_block;
                                    res.dma_bus_address = regs.bus_address;
                                    res.dma_bytes = bytes;
                                end
                                regs.bus_address = regs.bus_address + bytes[15:0];
                                regs.word_count = 16'd0;
                                if (!fits || refused)
                                    regs.status = regs.status | ST_END;
                            end
                            FN_STOP, FN_SSEL:
                                regs.status = regs.status;
                            default:
                                regs.status = regs.status | ST_ILO;
                        endcase
                        cm = (cm & ~CM_GO) | CM_DONE;
                        if ((regs.status & ST_ERRS) != 16'd0)
                            cm = cm | CM_ERR;
                        else
                            cm = cm & ~CM_ERR;
                        regs.command = cm;
                        regs.irq = ((cm & CM_IE) != 16'd0);
                    end
                    else
                        regs.irq = ((regs.command & CM_DONE) != 16'd0) &&
                                   ((regs.command & CM_IE) != 16'd0);
                end
                REG_COUNT:   regs.word_count = wdata;
                REG_ADDRESS: regs.bus_address = wdata;
                REG_DATA:    regs.data = wdata;
                default:     regs.data = regs.data;
            endcase
        end
        else
        begin
            case (idx)
                REG_STATUS:  res.read_data = regs.status;
                REG_COMMAND:
                begin
                    if ((regs.status & ST_ERRS) != 16'd0)
                        regs.command = regs.command | CM_ERR;
                    else
                        regs.command = regs.command & ~CM_ERR;
                    res.read_data = regs.command;
                end
                REG_COUNT:   res.read_data = regs.word_count;
                REG_ADDRESS: res.read_data = regs.bus_address;
                REG_DATA:    res.read_data = regs.data;
                default:     res.read_data = 16'd0;
            endcase
        end
        res.irq = regs.irq;
        return res;
    endfunction

    task automatic drive_access(input op_t op, input logic [2:0] idx,
                                input logic [15:0] wdata, input logic refused);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            access_bus.valid <= 1'b0;
            @(posedge clk);
        end
        access_bus.valid      <= 1'b1;
        access_bus.op         <= op;
        access_bus.reg_index  <= idx;
        access_bus.write_data <= wdata;
        access_bus.dma_error  <= refused;
        do
            @(posedge clk);
        while (!access_bus.ready);
        due_responses.push_back(tape_ctl_response(op, idx, wdata, refused));
    endtask

    // hold the bus quiet until every beat is back, then resize the tape
    task automatic set_tape_size(input logic [15:0] blocks);
        access_bus.valid <= 1'b0;
        @(posedge clk);
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= blocks;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        tape_blocks = blocks;
    endtask

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    task automatic random_traffic(input int count);
        int          sent;
        int          pick;
        logic [15:0] cmd;
        logic [15:0] value;
        func_t       fn;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    fn = FN_SEARCH;
                else if (pick < 70)
                    fn = ($urandom_range(0, 1) != 0) ? FN_READ : FN_WRITE;
                else
                    fn = func_t'($urandom_range(0, 7));
                cmd = 16'($urandom_range(0, 65535));
                cmd[3:1] = fn;
                cmd[0] = ($urandom_range(0, 99) < 85);
                drive_access(OP_WRITE, REG_COMMAND, cmd, $urandom_range(0, 4) == 0);
                sent++;
            end
            else if (pick < 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    value = 16'd0 - 16'($urandom_range(0, 1100));
                else if (pick < 60)
                    value = 16'd0;
                else
                    value = 16'($urandom_range(0, 65535));
                drive_access(OP_WRITE, REG_COUNT, value, 1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 50)
            begin
                drive_access(OP_WRITE, REG_ADDRESS, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 55)
            begin
                drive_access(OP_WRITE, REG_DATA, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 60)
            begin
                value = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 1) != 0)
                    drive_access(OP_WRITE, REG_STATUS, value, 1'($urandom_range(0, 1)));
                else
                    drive_access(OP_WRITE, 3'($urandom_range(5, 7)), value,
                                 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                drive_access(OP_READ, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    task automatic test_reset_state();
        for (int i = 0; i < 8; i++)
            drive_access(OP_READ, 3'(i), 16'hFFFF, 1'b1);
    endtask

    task automatic test_plain_registers();
        drive_access(OP_WRITE, REG_STATUS, 16'hFFFF, 1'b0);
        drive_access(OP_WRITE, LAST_UNMAPPED, 16'hFFFF, 1'b1);
        drive_access(OP_WRITE, REG_COUNT, 16'hFF00, 1'b0);
        drive_access(OP_WRITE, REG_ADDRESS, 16'hFFFF, 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, 16'hFFFE, 1'b0);
        drive_access(OP_READ, REG_COMMAND, 16'h0000, 1'b0);
    endtask

    task automatic test_functions();
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_SEARCH, CM_GO | CM_IE), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND,
                     command_word(FN_SEARCH, CM_GO | CM_IE | CM_DIR), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND,
                     command_word(FN_SEARCH, CM_GO | CM_IE | CM_DIR), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_READ, CM_GO | CM_IE), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_WRITE, CM_GO | CM_IE), 1'b1);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_READ_ALL, CM_GO), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_WRITE_ALL, CM_GO | CM_IE), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_WRITE_TIMING, CM_GO), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_STOP, CM_GO | CM_IE), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_SSEL, CM_GO), 1'b0);
    endtask

    task automatic test_tape_ends();
        set_tape_size(16'd1);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_SEARCH, CM_GO), 1'b0);
        drive_access(OP_WRITE, REG_COUNT, 16'hFEFF, 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_READ, CM_GO | CM_IE), 1'b0);
        drive_access(OP_READ, REG_COMMAND, 16'h0000, 1'b0);
        set_tape_size(16'd0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_READ, CM_GO), 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_SEARCH, CM_GO), 1'b0);
        set_tape_size(16'hFFFF);
        drive_access(OP_WRITE, REG_COUNT, 16'h0001, 1'b0);
        drive_access(OP_WRITE, REG_COMMAND, command_word(FN_WRITE, CM_GO), 1'b0);
    endtask

    task automatic test_random_traffic();
        tx_idle_pct = 35;
        rx_idle_pct = 45;
        set_tape_size(16'hFFFF);
        random_traffic(325);
        set_tape_size(16'($urandom_range(1, 8)));
        random_traffic(325);
        tx_idle_pct = 45;
        rx_idle_pct = 35;
        set_tape_size(NUM_BLOCKS_RESET);
        random_traffic(325);
        set_tape_size(16'd1);
        random_traffic(325);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_tape_size(16'($urandom_range(1, 65535)));
        random_traffic(325);
        set_tape_size(16'($urandom_range(2, 40)));
        random_traffic(325);
    endtask

    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result beat with nothing expected, read_data %0h",
                                 result_bus.read_data);
                end
                else
                begin
                    want = due_responses.pop_front();
                    check_field("read_data", 17'(want.read_data),
                                17'(result_bus.read_data));
                    check_field("irq", 17'(want.irq), 17'(result_bus.irq));
                    check_field("dma_request", 17'(want.dma_request),
                                17'(result_bus.dma_request));
                    check_field("dma_to_memory", 17'(want.dma_to_memory),
                                17'(result_bus.dma_to_memory));
                    check_field("dma_block", 17'(want.dma_block),
                                17'(result_bus.dma_block));
                    check_field("dma_bus_address", 17'(want.dma_bus_address),
                                17'(result_bus.dma_bus_address));
                    check_field("dma_bytes", want.dma_bytes, result_bus.dma_bytes);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_write_en          <= 1'b0;
        cfg_write_data        <= 16'd0;
        access_bus.valid      <= 1'b0;
        access_bus.op         <= OP_READ;
        access_bus.reg_index  <= REG_STATUS;
        access_bus.write_data <= 16'd0;
        access_bus.dma_error  <= 1'b0;
        mismatches  = 0;
        tx_idle_pct = 35;
        rx_idle_pct = 45;
        tape_blocks = NUM_BLOCKS_RESET;
        regs = '0;
        regs.status  = ST_UPS;
        regs.command = CM_DONE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_plain_registers();
        test_functions();
        test_tape_ends();
        test_random_traffic();

        access_bus.valid <= 1'b0;
        @(posedge clk);
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0 && due_responses.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
